@@ rtl/core/beacon_element_parser_assert.svh @@
// ----------------------------------------------------------------------------
// beacon_element_parser_assert.svh
// Assertion macros used by the beacon element parser RTL.
// ----------------------------------------------------------------------------
`ifndef BEACON_ELEMENT_PARSER_ASSERT_SVH
`define BEACON_ELEMENT_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define BEP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define BEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bep_pkg.sv @@
// ----------------------------------------------------------------------------
// bep_pkg
// Types, constants and helpers for the beacon element parser.
// ----------------------------------------------------------------------------
package bep_pkg;

    // Store size default (bytes of SSID kept per bank)
    localparam int SSID_BYTES_DEF = 32;

    // Fixed field widths of the result item
    localparam int SSID_LEN_W = 6;
    localparam int FREQ_W     = 13;

    // Fixed beacon body fields: timestamp, interval, capability
    localparam logic [3:0] HEADER_BYTES = 4'd12;

    // Element ids
    localparam logic [7:0] ID_SSID = 8'd0;
    localparam logic [7:0] ID_DS   = 8'd3;
    localparam logic [7:0] ID_HT   = 8'd61;
    localparam logic [7:0] ID_VHT  = 8'd192;
    localparam logic [7:0] ID_EXT  = 8'd255;

    // Extension id of HE operation
    localparam logic [7:0] EXT_HE_OP = 8'd36;

    // Width field masks
    localparam logic [7:0] HT_CHW_MASK = 8'h03;
    localparam logic [7:0] HE_CHW_MASK = 8'h07;

    // VHT channel width codes
    localparam logic [7:0] VHT_W_40     = 8'd0;
    localparam logic [7:0] VHT_W_80     = 8'd1;
    localparam logic [7:0] VHT_W_160    = 8'd2;
    localparam logic [7:0] VHT_W_80P80  = 8'd3;

    // HE width thresholds (masked field)
    localparam logic [7:0] HE_W_80  = 8'd2;
    localparam logic [7:0] HE_W_160 = 8'd3;

    // Minimum element lengths
    localparam logic [7:0] LEN_DS_MIN  = 8'd1;
    localparam logic [7:0] LEN_HT_MIN  = 8'd2;
    localparam logic [7:0] LEN_VHT_MIN = 8'd3;
    localparam logic [7:0] LEN_HE_MIN  = 8'd1;
    localparam logic [7:0] LEN_HE_FULL = 8'd7;

    // Value byte positions that are kept
    localparam logic [7:0] POS_VAL0 = 8'd0;
    localparam logic [7:0] POS_VAL1 = 8'd1;
    localparam logic [7:0] POS_VAL4 = 8'd4;

    // Bandwidth codes
    localparam logic [1:0] BW_20  = 2'd0;
    localparam logic [1:0] BW_40  = 2'd1;
    localparam logic [1:0] BW_80  = 2'd2;
    localparam logic [1:0] BW_160 = 2'd3;

    localparam logic [7:0] BW_MHZ_20  = 8'd20;
    localparam logic [7:0] BW_MHZ_40  = 8'd40;
    localparam logic [7:0] BW_MHZ_80  = 8'd80;
    localparam logic [7:0] BW_MHZ_160 = 8'd160;

    // PHY standard codes
    localparam logic [1:0] STD_N  = 2'd0;
    localparam logic [1:0] STD_AC = 2'd1;
    localparam logic [1:0] STD_AX = 2'd2;

    // Result kinds
    localparam logic KIND_SSID    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Reset value of the scan channel register
    localparam logic [7:0] SCAN_CH_RESET = 8'd36;

    // 5 GHz band base frequency
    localparam logic [FREQ_W-1:0] FREQ_BASE = 13'd5000;

    // Element walk phase
    typedef enum logic [2:0] {
        PH_ID  = 3'b001,
        PH_LEN = 3'b010,
        PH_VAL = 3'b100
    } phase_t;

    // Input item
    typedef struct packed {
        logic [7:0] body_byte;
        logic       last_byte;
    } bep_in_t;

    // Result item
    typedef struct packed {
        logic                  result_kind;
        logic [7:0]            ssid_char;
        logic                  ssid_valid;
        logic [SSID_LEN_W-1:0] ssid_len;
        logic [7:0]            channel_number;
        logic [7:0]            bandwidth_mhz;
        logic [1:0]            phy_standard;
        logic [FREQ_W-1:0]     primary_freq_mhz;
        logic [FREQ_W-1:0]     secondary_freq_mhz;
        logic                  last_result;
    } bep_res_t;

    // Bandwidth code to MHz
    function automatic logic [7:0] bw_to_mhz(input logic [1:0] code);
        logic [7:0] mhz;
        case (code)
            BW_20:   mhz = BW_MHZ_20;
            BW_40:   mhz = BW_MHZ_40;
            BW_80:   mhz = BW_MHZ_80;
            default: mhz = BW_MHZ_160;
        endcase
        return mhz;
    endfunction

    // 5000 + 5 * channel, as shift and add
    function automatic logic [FREQ_W-1:0] chan_to_freq(input logic [7:0] ch);
        return FREQ_BASE + {3'b000, ch, 2'b00} + {5'b00000, ch};
    endfunction

endpackage

@@ rtl/core/bep_stream_if.sv @@
// ----------------------------------------------------------------------------
// bep_stream_if
// Valid/ready channel carrying one item of type T per handshake.
// ----------------------------------------------------------------------------
interface bep_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ rtl/core/bep_ram.sv @@
// ----------------------------------------------------------------------------
// bep_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/beacon_element_parser.sv @@
// ----------------------------------------------------------------------------
// beacon_element_parser
// Takes one beacon body byte per cycle, skips the 12 fixed bytes and walks
// the information elements; each element acts when its last byte arrives.
// SSID bytes go to one bank of a two-bank store and the bank flips when the
// element completes. On the final byte the block drains the committed SSID
// (up to SSID_BYTES items) and then one summary item, one item per cycle
// while result_ch is ready, through an output register fed by the store's
// registered read port, so a frame keeping n SSID bytes yields n + 1 items.
// While a frame drains, next-frame bytes keep being accepted one per cycle;
// only the next final byte, and an SSID byte that would land in the bank
// being drained, wait until the drain is done.
// ----------------------------------------------------------------------------
module beacon_element_parser
    import bep_pkg::*;
#(
    parameter int SSID_BYTES = SSID_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    bep_stream_if.sink       byte_ch,
    bep_stream_if.source     result_ch
);

    `include "beacon_element_parser_assert.svh"

    localparam int LEN_W  = $clog2(SSID_BYTES + 1);
    localparam int DEPTH  = 2 * SSID_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef struct packed {
        logic [3:0]       header_count;
        phase_t           phase;
        logic [7:0]       elem_id;
        logic [7:0]       elem_len;
        logic [7:0]       elem_pos;
        logic [7:0]       val0;
        logic [7:0]       val1;
        logic [7:0]       val4;
        logic [7:0]       channel;
        logic [1:0]       bw_code;
        logic [1:0]       std_code;
        logic [7:0]       sc_chan;
        logic             sc_set;
        logic             found;
        logic             bank;
        logic [LEN_W-1:0] ssid_length;
        logic [LEN_W-1:0] staging;
    } parse_t;

    typedef struct packed {
        logic             found;
        logic             bank;
        logic [LEN_W-1:0] ssid_length;
        logic [7:0]       channel;
        logic [1:0]       bw_code;
        logic [1:0]       std_code;
        logic [7:0]       sc_chan;
        logic             sc_set;
    } snap_t;

    logic [7:0]       scan_channel_reg;
    parse_t           parse_reg, parse_upd, parse_next;
    snap_t            snap_reg, snap_next;
    logic             emit_active_reg, emit_active_next;
    logic [LEN_W-1:0] emit_idx_reg, emit_idx_next;
    logic             res_valid_reg, res_valid_next;
    bep_res_t         res_reg, res_next, res_out;

    logic              byte_acc;
    logic              finish;
    logic              ssid_wr_pending;
    logic              res_adv;
    logic              ram_we;
    logic              wr_bank;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [FREQ_W-1:0] prim_freq;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_channel_reg <= SCAN_CH_RESET;
        end
        else if (cfg_we)
        begin
            scan_channel_reg <= cfg_wdata;
        end
    end

    // Input handshake: hold the next final byte and clashing SSID writes
    assign wr_bank         = ~parse_reg.bank;
    assign ssid_wr_pending = (parse_reg.phase == PH_VAL) && (parse_reg.elem_id == ID_SSID)
                             && ({1'b0, parse_reg.elem_pos} < 9'(SSID_BYTES))
                             && (wr_bank == snap_reg.bank);
    assign byte_ch.ready   = !(emit_active_reg
                               && (byte_ch.data.last_byte || ssid_wr_pending));
    assign byte_acc        = byte_ch.valid && byte_ch.ready;

    // Element walk and element completion
    always_comb
    begin
        parse_upd = parse_reg;
        finish    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = wr_bank ? ADDR_W'(SSID_BYTES) + ADDR_W'(parse_reg.elem_pos)
                            : ADDR_W'(parse_reg.elem_pos);
        if (byte_acc)
        begin
            if (parse_reg.header_count == 4'd0)
            begin
                parse_upd.channel = scan_channel_reg;
            end
            if (parse_reg.header_count < HEADER_BYTES)
            begin
                parse_upd.header_count = parse_reg.header_count + 4'd1;
            end
            else
            begin
                unique case (parse_reg.phase)
                    PH_ID:
                    begin
                        parse_upd.elem_id = byte_ch.data.body_byte;
                        parse_upd.phase   = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        parse_upd.elem_len = byte_ch.data.body_byte;
                        parse_upd.elem_pos = 8'd0;
                        parse_upd.staging  = '0;
                        if (byte_ch.data.body_byte == 8'd0)
                        begin
                            finish          = 1'b1;
                            parse_upd.phase = PH_ID;
                        end
                        else
                        begin
                            parse_upd.phase = PH_VAL;
                        end
                    end
                    PH_VAL:
                    begin
                        if (parse_reg.elem_pos == POS_VAL0)
                        begin
                            parse_upd.val0 = byte_ch.data.body_byte;
                        end
                        if (parse_reg.elem_pos == POS_VAL1)
                        begin
                            parse_upd.val1 = byte_ch.data.body_byte;
                        end
                        if (parse_reg.elem_pos == POS_VAL4)
                        begin
                            parse_upd.val4 = byte_ch.data.body_byte;
                        end
                        if ((parse_reg.elem_id == ID_SSID)
                            && ({1'b0, parse_reg.elem_pos} < 9'(SSID_BYTES)))
                        begin
                            ram_we            = 1'b1;
                            parse_upd.staging = LEN_W'({1'b0, parse_reg.elem_pos} + 9'd1);
                        end
                        if (({1'b0, parse_reg.elem_pos} + 9'd1) >= {1'b0, parse_reg.elem_len})
                        begin
                            finish          = 1'b1;
                            parse_upd.phase = PH_ID;
                        end
                        else
                        begin
                            parse_upd.elem_pos = parse_reg.elem_pos + 8'd1;
                        end
                    end
                    default:
                    begin
                        parse_upd.phase = PH_ID;
                    end
                endcase
            end

            // Completed element takes effect
            if (finish)
            begin
                unique case (parse_upd.elem_id)
                    ID_SSID:
                    begin
                        parse_upd.found       = 1'b1;
                        parse_upd.bank        = ~parse_upd.bank;
                        parse_upd.ssid_length = parse_upd.staging;
                    end
                    ID_DS:
                    begin
                        if (parse_upd.elem_len >= LEN_DS_MIN)
                        begin
                            parse_upd.channel = parse_upd.val0;
                        end
                    end
                    ID_HT:
                    begin
                        if (parse_upd.elem_len >= LEN_HT_MIN)
                        begin
                            if (((parse_upd.val1 & HT_CHW_MASK) != 8'd0)
                                && (parse_upd.bw_code < BW_40))
                            begin
                                parse_upd.bw_code = BW_40;
                            end
                            parse_upd.std_code = STD_N;
                        end
                    end
                    ID_VHT:
                    begin
                        if (parse_upd.elem_len >= LEN_VHT_MIN)
                        begin
                            if (parse_upd.val0 == VHT_W_40)
                            begin
                                if (parse_upd.bw_code < BW_40)
                                begin
                                    parse_upd.bw_code = BW_40;
                                end
                            end
                            else if (parse_upd.val0 == VHT_W_80)
                            begin
                                parse_upd.bw_code = BW_80;
                                parse_upd.sc_chan = parse_upd.val1;
                                parse_upd.sc_set  = 1'b1;
                            end
                            else if ((parse_upd.val0 == VHT_W_160)
                                     || (parse_upd.val0 == VHT_W_80P80))
                            begin
                                parse_upd.bw_code = BW_160;
                            end
                            parse_upd.std_code = STD_AC;
                        end
                    end
                    ID_EXT:
                    begin
                        if ((parse_upd.elem_len >= LEN_HE_MIN)
                            && (parse_upd.val0 == EXT_HE_OP))
                        begin
                            parse_upd.std_code = STD_AX;
                            if (parse_upd.elem_len >= LEN_HE_FULL)
                            begin
                                if (((parse_upd.val4 & HE_CHW_MASK) >= HE_W_80)
                                    && (parse_upd.bw_code < BW_80))
                                begin
                                    parse_upd.bw_code = BW_80;
                                end
                                if ((parse_upd.val4 & HE_CHW_MASK) >= HE_W_160)
                                begin
                                    parse_upd.bw_code = BW_160;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        parse_upd.std_code = parse_upd.std_code;
                    end
                endcase
            end
        end
    end

    // Frame end: state back to frame start, store bank kept
    always_comb
    begin
        parse_next = parse_upd;
        if (byte_acc && byte_ch.data.last_byte)
        begin
            parse_next         = '0;
            parse_next.phase   = PH_ID;
            parse_next.channel = scan_channel_reg;
            parse_next.bank    = parse_upd.bank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg         <= '0;
            parse_reg.phase   <= PH_ID;
            parse_reg.channel <= SCAN_CH_RESET;
        end
        else
        begin
            parse_reg <= parse_next;
        end
    end

    // SSID store, two banks
    bep_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ssid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_ch.data.body_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Drain sequencer and output register
    assign res_adv   = !res_valid_reg || result_ch.ready;
    assign ram_raddr = snap_reg.bank ? ADDR_W'(SSID_BYTES) + ADDR_W'(emit_idx_reg)
                                     : ADDR_W'(emit_idx_reg);
    assign prim_freq = chan_to_freq(snap_reg.channel);

    always_comb
    begin
        emit_active_next = emit_active_reg;
        emit_idx_next    = emit_idx_reg;
        snap_next        = snap_reg;
        res_valid_next   = res_valid_reg;
        res_next         = res_reg;
        ram_re           = 1'b0;
        if (res_adv)
        begin
            res_valid_next = 1'b0;
            if (emit_active_reg)
            begin
                res_valid_next      = 1'b1;
                res_next            = '0;
                res_next.ssid_valid = snap_reg.found;
                res_next.ssid_len   = SSID_LEN_W'(snap_reg.ssid_length);
                if (emit_idx_reg < snap_reg.ssid_length)
                begin
                    ram_re               = 1'b1;
                    res_next.result_kind = KIND_SSID;
                    emit_idx_next        = emit_idx_reg + LEN_W'(1);
                end
                else
                begin
                    res_next.result_kind        = KIND_SUMMARY;
                    res_next.channel_number     = snap_reg.channel;
                    res_next.bandwidth_mhz      = bw_to_mhz(snap_reg.bw_code);
                    res_next.phy_standard       = snap_reg.std_code;
                    res_next.primary_freq_mhz   = prim_freq;
                    res_next.secondary_freq_mhz = snap_reg.sc_set
                                                  ? chan_to_freq(snap_reg.sc_chan)
                                                  : prim_freq;
                    res_next.last_result        = 1'b1;
                    emit_active_next            = 1'b0;
                end
            end
        end
        // Snapshot of the finished frame
        if (byte_acc && byte_ch.data.last_byte)
        begin
            emit_active_next      = 1'b1;
            emit_idx_next         = '0;
            snap_next.found       = parse_upd.found;
            snap_next.bank        = parse_upd.bank;
            snap_next.ssid_length = parse_upd.ssid_length;
            snap_next.channel     = parse_upd.channel;
            snap_next.bw_code     = parse_upd.bw_code;
            snap_next.std_code    = parse_upd.std_code;
            snap_next.sc_chan     = parse_upd.sc_chan;
            snap_next.sc_set      = parse_upd.sc_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_active_reg <= 1'b0;
            emit_idx_reg    <= '0;
            snap_reg        <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            emit_active_reg <= emit_active_next;
            emit_idx_reg    <= emit_idx_next;
            snap_reg        <= snap_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // SSID byte comes straight from the store's read register
    always_comb
    begin
        res_out           = res_reg;
        res_out.ssid_char = (res_reg.result_kind == KIND_SSID) ? ram_rdata : 8'd0;
    end

    assign result_ch.valid = res_valid_reg;
    assign result_ch.data  = res_out;

    // Checks
    `BEP_ASSERT_IMPLIES(a_no_bank_clash, clk, rst_n, ram_we && emit_active_reg, wr_bank != snap_reg.bank, "SSID write hit the bank being drained")
    `BEP_ASSERT_IMPLIES(a_idx_in_range, clk, rst_n, emit_active_reg, emit_idx_reg <= snap_reg.ssid_length, "drain index past SSID length")
    `BEP_ASSERT_NEXT(a_drain_starts, clk, rst_n, byte_acc && byte_ch.data.last_byte, emit_active_reg, "final byte did not start a drain")
    `BEP_ASSERT_IMPLIES(a_last_is_summary, clk, rst_n, result_ch.valid, result_ch.data.last_result == result_ch.data.result_kind, "last_result not on the summary item")

endmodule
